>>> rtl/obb_overlap_test_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the oriented box overlap unit
// Concurrent assertion wrappers clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef OBB_OVERLAP_TEST_UNIT_ASSERT_SVH
`define OBB_OVERLAP_TEST_UNIT_ASSERT_SVH
// Same-cycle implication.
`define OBB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define OBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg
// Shared types, constants and saturating fixed point helpers.
// ----------------------------------------------------------------------------
package obb_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned QueueDepDef = 2;
  localparam int unsigned VecPerBox   = 5;
  localparam int unsigned NumRows     = 2 * VecPerBox;
  localparam int unsigned RowW        = $clog2(NumRows);
  localparam int unsigned VecW        = 3 * DataW;

  localparam logic [2:0] KindCentre = 3'd0;
  localparam logic [2:0] KindAxis0  = 3'd1;
  localparam logic [2:0] KindHalf   = 3'd4;

  typedef logic signed [DataW-1:0]   fx_t;
  typedef logic signed [2*DataW-1:0] wide_t;
  typedef fx_t [2:0]                 vec3_t;

  localparam fx_t FxMax = {1'b0, {(DataW-1){1'b1}}};
  localparam fx_t FxMin = {1'b1, {(DataW-1){1'b0}}};
  localparam fx_t FxLsb = fx_t'(1);

  typedef struct packed {
    logic            store;
    logic [RowW-1:0] row;
    logic [VecW-1:0] vec;
    logic            last;
  } item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_CA, S_LD_CB, S_T, S_AX, S_AX2, S_AX3, S_CR, S_SQ, S_SQRT,
    S_LEN, S_DIV, S_DIVE, S_DIST, S_HLD, S_HCAP, S_EV, S_EV2, S_EDOT,
    S_EMUL, S_EACC, S_CMP, S_NEXT, S_DONE
  } bstate_e;

  typedef enum logic [1:0] {
    GrpFaceA, GrpFaceB, GrpCross
  } grp_e;

  function automatic logic [RowW-1:0] row_of(input logic box, input logic [2:0] kind);
    logic [RowW-1:0] r;
    r = RowW'(kind);
    if (box) begin
      r = r + RowW'(VecPerBox);
    end
    return r;
  endfunction

  function automatic fx_t sat_add(input fx_t a, input fx_t b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) begin
      return s[DataW] ? FxMin : FxMax;
    end
    return s[DataW-1:0];
  endfunction

  function automatic fx_t sat_sub(input fx_t a, input fx_t b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} - {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) begin
      return s[DataW] ? FxMin : FxMax;
    end
    return s[DataW-1:0];
  endfunction

  function automatic fx_t fx_abs(input fx_t a);
    if (a == FxMin) begin
      return FxMax;
    end
    return a[DataW-1] ? -a : a;
  endfunction

  function automatic fx_t sat_wide(input wide_t v);
    if (!v[2*DataW-1] && (|v[2*DataW-2:DataW-1])) begin
      return FxMax;
    end
    if (v[2*DataW-1] && !(&v[2*DataW-2:DataW-1])) begin
      return FxMin;
    end
    return v[DataW-1:0];
  endfunction

  // Rescale a raw product, truncating toward zero, then saturate.
  function automatic fx_t fx_scale(input wide_t p, input int unsigned frac);
    wide_t bias;
    bias = p[2*DataW-1] ? ((wide_t'(1) <<< frac) - wide_t'(1)) : wide_t'(0);
    return sat_wide((p + bias) >>> frac);
  endfunction

endpackage

>>> rtl/obb_overlap_test_unit.sv
// ----------------------------------------------------------------------------
// obb_overlap_test_unit
// Separating-axis overlap test for two oriented boxes, fixed point.
// Input channel (push/full): one item per transfer loads a 3-vector (centre,
//   axis 0..2 or half sizes) of either box into a ten-row vector store that
//   reset clears. A transfer flagged last stores its vector, then runs the
//   test over the 15 candidate axes (3 + 3 face axes, 9 cross axes).
// Result channel (empty/pop): one overlap flag per last item, oldest first.
// A plain load is stored straight from the idle state. A test sweeps the face
//   axes, then the cross axes, each cross axis with a 32-step square root
//   plus three 32+FRAC_BITS step divisions; it ends early when an axis
//   separates, and a degenerate cross axis skips its divisions and extents.
//   The shared multiplier and the bit-serial root and divide unit set the pace.
// Two-entry queues sit on both sides: loads keep arriving while a test runs
//   until the input queue fills, and a stalled receiver only stops the engine
//   before it starts the next test.
// Reset: all queues empty, every stored vector reads as zero.
// ----------------------------------------------------------------------------
module obb_overlap_test_unit #(
  parameter int unsigned FRAC_BITS  = obb_pkg::FracBitsDef,
  parameter int unsigned QueueDepth = obb_pkg::QueueDepDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               box_select_i,
  input  logic [2:0]         vector_kind_i,
  input  logic signed [31:0] comp_x_i,
  input  logic signed [31:0] comp_y_i,
  input  logic signed [31:0] comp_z_i,
  input  logic               last_i,
  output logic               empty,
  input  logic               pop,
  output logic               overlap_o
);
  import obb_pkg::*;

  item_t item;
  logic  item_empty, item_pop;
  logic  res_full, res_push, res_bit;

  // Front: classify loads and hold them in the input queue.
  obb_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .box_select_i  (box_select_i),
    .vector_kind_i (vector_kind_i),
    .comp_x_i      (comp_x_i),
    .comp_y_i      (comp_y_i),
    .comp_z_i      (comp_z_i),
    .last_i        (last_i),
    .item_o        (item),
    .item_empty_o  (item_empty),
    .item_pop_i    (item_pop)
  );

  // Back: store vectors and run the axis sweep.
  obb_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_empty_i (item_empty),
    .item_pop_o   (item_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_bit)
  );

  // Result queue: hold flags until the receiver pops them.
  obb_fifo #(
    .Width (1),
    .Depth (QueueDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_bit),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (overlap_o),
    .empty_o (empty)
  );

endmodule

>>> rtl/obb_fifo.sv
// ----------------------------------------------------------------------------
// obb_fifo
// Small synchronous queue with full and empty flags.
// ----------------------------------------------------------------------------
module obb_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/obb_ram.sv
// ----------------------------------------------------------------------------
// obb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module obb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/obb_front.sv
// ----------------------------------------------------------------------------
// obb_front
// Input side: classify each load and queue it for the test engine.
// ----------------------------------------------------------------------------
module obb_front #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                box_select_i,
  input  logic [2:0]          vector_kind_i,
  input  logic signed [31:0]  comp_x_i,
  input  logic signed [31:0]  comp_y_i,
  input  logic signed [31:0]  comp_z_i,
  input  logic                last_i,
  output obb_pkg::item_t      item_o,
  output logic                item_empty_o,
  input  logic                item_pop_i
);
  import obb_pkg::*;

  item_t                 cls;
  logic [$bits(item_t)-1:0] q_data;

  // Kinds beyond the half sizes are queued but store nothing.
  always_comb begin
    cls.store = (vector_kind_i <= KindHalf);
    cls.row   = cls.store ? row_of(box_select_i, vector_kind_i) : '0;
    cls.vec   = {comp_z_i, comp_y_i, comp_x_i};
    cls.last  = last_i;
  end

  obb_fifo #(
    .Width ($bits(item_t)),
    .Depth (QueueDepth)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls),
    .full_o  (full),
    .pop_i   (item_pop_i),
    .data_o  (q_data),
    .empty_o (item_empty_o)
  );

  assign item_o = item_t'(q_data);

endmodule

>>> rtl/obb_back.sv
// ----------------------------------------------------------------------------
// obb_back
// Test engine: vector store, shared multiplier, sqrt and divide sequencer.
// ----------------------------------------------------------------------------
module obb_back #(
  parameter int unsigned FRAC_BITS = obb_pkg::FracBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  obb_pkg::item_t item_i,
  input  logic           item_empty_i,
  output logic           item_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output logic           res_o
);
  import obb_pkg::*;

  localparam int unsigned DivW = DataW + FRAC_BITS;
  localparam int unsigned CntW = $clog2(DivW + 1);

  bstate_e         state_q, state_d;
  grp_e            grp_q;
  logic [1:0]      i_q, j_q, k_q;
  logic            side_q;
  logic [CntW-1:0] cnt_q;
  logic [1:0]      idx;

  vec3_t           d_q, t_q, v_q, w_q, h_q, rd_vec;
  fx_t             acc_q, tmp_q, ext_q, own_q, dist_q;
  fx_t             mul_a, mul_b, prod, absv, eval;
  wide_t           p_q;

  logic [2*DataW-1:0] rem_q, res_q, bit_q, trial;
  logic [DataW-1:0]   len_q;
  logic [DivW-1:0]    dvd_q;
  logic [DataW-1:0]   drem_q;
  logic [DataW:0]     dpart;
  logic               neg_q, ovl_q, plus1, last_axis, sep;

  logic [NumRows-1:0] vld_q;
  logic               rd_vld_q;
  logic [RowW-1:0]    rd_addr;
  logic [VecW-1:0]    ram_rdata;
  fx_t                qsat;

  obb_ram #(
    .Width (VecW),
    .Depth (NumRows)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (item_pop_o & item_i.store),
    .waddr_i (item_i.row),
    .wdata_i (item_i.vec),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Rows never written read as zero.
  assign rd_vec = rd_vld_q ? vec3_t'(ram_rdata) : vec3_t'('0);
  assign idx    = cnt_q[1:0];
  assign prod   = fx_scale(p_q, FRAC_BITS);
  assign absv   = fx_abs(acc_q);
  assign plus1  = (!side_q && grp_q == GrpFaceB) || (side_q && grp_q == GrpFaceA);
  assign eval   = plus1 ? sat_add(absv, FxLsb) : absv;
  assign trial  = res_q + bit_q;
  assign dpart  = {drem_q, dvd_q[DivW-1]};
  assign sep    = $signed(dist_q) > $signed(sat_add(own_q, ext_q));
  assign last_axis = (grp_q == GrpCross) && (i_q == 2'd2) && (j_q == 2'd2);

  // Saturate the signed quotient.
  always_comb begin
    if (neg_q) begin
      qsat = ((|dvd_q[DivW-1:DataW]) || (dvd_q[DataW-1] && (|dvd_q[DataW-2:0])))
             ? FxMin : -fx_t'(dvd_q[DataW-1:0]);
    end else begin
      qsat = (|dvd_q[DivW-1:DataW-1]) ? FxMax : fx_t'(dvd_q[DataW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
      if (item_pop_o && item_i.store) begin
        vld_q[item_i.row] <= 1'b1;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    rd_addr    = '0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (!item_empty_i && (!item_i.last || !res_full_i)) begin
          item_pop_o = 1'b1;
          if (item_i.last) begin
            state_d = S_LD_CA;
          end
        end
      end
      S_LD_CA: begin
        rd_addr = row_of(1'b0, KindCentre);
        state_d = S_LD_CB;
      end
      S_LD_CB: begin
        rd_addr = row_of(1'b1, KindCentre);
        state_d = S_T;
      end
      S_T: state_d = S_AX;
      S_AX: begin
        rd_addr = row_of(grp_q == GrpFaceB, KindAxis0 + 3'(i_q));
        state_d = S_AX2;
      end
      S_AX2: begin
        if (grp_q == GrpCross) begin
          rd_addr = row_of(1'b1, KindAxis0 + 3'(j_q));
          state_d = S_AX3;
        end else begin
          state_d = S_DIST;
        end
      end
      S_AX3: state_d = S_CR;
      S_CR: begin
        unique case (cnt_q)
          CntW'(0): begin mul_a = v_q[1]; mul_b = w_q[2]; end
          CntW'(1): begin mul_a = v_q[2]; mul_b = w_q[1]; end
          CntW'(2): begin mul_a = v_q[2]; mul_b = w_q[0]; end
          CntW'(3): begin mul_a = v_q[0]; mul_b = w_q[2]; end
          CntW'(4): begin mul_a = v_q[0]; mul_b = w_q[1]; end
          CntW'(5): begin mul_a = v_q[1]; mul_b = w_q[0]; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        if (cnt_q == CntW'(6)) begin
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        mul_a = d_q[idx];
        mul_b = d_q[idx];
        if (cnt_q == CntW'(3)) begin
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (cnt_q == CntW'(DataW - 1)) begin
          state_d = S_LEN;
        end
      end
      S_LEN: state_d = (res_q == '0) ? S_NEXT : S_DIV;
      S_DIV: begin
        if (cnt_q == CntW'(DivW - 1)) begin
          state_d = S_DIVE;
        end
      end
      S_DIVE: state_d = (k_q == 2'd2) ? S_DIST : S_DIV;
      S_DIST: begin
        mul_a = t_q[idx];
        mul_b = d_q[idx];
        if (cnt_q == CntW'(3)) begin
          state_d = S_HLD;
        end
      end
      S_HLD: begin
        rd_addr = row_of(side_q, KindHalf);
        state_d = S_HCAP;
      end
      S_HCAP: state_d = S_EV;
      S_EV: begin
        rd_addr = row_of(side_q, KindAxis0 + 3'(k_q));
        state_d = S_EV2;
      end
      S_EV2: state_d = S_EDOT;
      S_EDOT: begin
        mul_a = v_q[idx];
        mul_b = d_q[idx];
        if (cnt_q == CntW'(3)) begin
          state_d = S_EMUL;
        end
      end
      S_EMUL: begin
        mul_a   = h_q[k_q];
        mul_b   = eval;
        state_d = S_EACC;
      end
      S_EACC: begin
        if (k_q != 2'd2) begin
          state_d = S_EV;
        end else begin
          state_d = side_q ? S_CMP : S_HLD;
        end
      end
      S_CMP:  state_d = sep ? S_DONE : S_NEXT;
      S_NEXT: state_d = last_axis ? S_DONE : S_AX;
      S_DONE: begin
        res_push_o = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_o = ovl_q;

  always_ff @(posedge clk_i) begin
    p_q      <= wide_t'(mul_a) * wide_t'(mul_b);
    rd_vld_q <= vld_q[rd_addr];
    unique case (state_q)
      S_IDLE: begin
        grp_q <= GrpFaceA;
        i_q   <= '0;
        j_q   <= '0;
        ovl_q <= 1'b1;
      end
      S_LD_CB: v_q <= rd_vec;
      S_T: begin
        for (int c = 0; c < 3; c++) begin
          t_q[c] <= sat_sub(rd_vec[c], v_q[c]);
        end
      end
      S_AX2: begin
        if (grp_q == GrpCross) begin
          v_q <= rd_vec;
        end else begin
          d_q <= rd_vec;
        end
      end
      S_AX3: w_q <= rd_vec;
      S_CR: begin
        if (cnt_q != '0) begin
          if (!cnt_q[0]) begin
            d_q[cnt_q[2:1] - 2'd1] <= sat_sub(tmp_q, prod);
          end else begin
            tmp_q <= prod;
          end
        end
      end
      S_SQ: begin
        if (cnt_q == '0) begin
          rem_q <= '0;
        end else begin
          rem_q <= rem_q + p_q;
        end
        res_q <= '0;
        bit_q <= {2'b01, {(2*DataW-2){1'b0}}};
      end
      S_SQRT: begin
        if (rem_q >= trial) begin
          rem_q <= rem_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_LEN: begin
        len_q  <= res_q[DataW-1:0];
        k_q    <= '0;
        neg_q  <= d_q[0][DataW-1];
        dvd_q  <= {(d_q[0][DataW-1] ? (~d_q[0] + 1'b1) : d_q[0]), {FRAC_BITS{1'b0}}};
        drem_q <= '0;
      end
      S_DIV: begin
        if (dpart >= {1'b0, len_q}) begin
          drem_q <= DataW'(dpart - {1'b0, len_q});
          dvd_q  <= {dvd_q[DivW-2:0], 1'b1};
        end else begin
          drem_q <= dpart[DataW-1:0];
          dvd_q  <= {dvd_q[DivW-2:0], 1'b0};
        end
      end
      S_DIVE: begin
        d_q[k_q] <= qsat;
        if (k_q != 2'd2) begin
          k_q    <= k_q + 2'd1;
          neg_q  <= d_q[k_q + 2'd1][DataW-1];
          dvd_q  <= {(d_q[k_q + 2'd1][DataW-1] ? (~d_q[k_q + 2'd1] + 1'b1)
                                                : d_q[k_q + 2'd1]), {FRAC_BITS{1'b0}}};
          drem_q <= '0;
        end
      end
      S_DIST, S_EDOT: begin
        acc_q <= (cnt_q == '0) ? '0 : sat_add(acc_q, prod);
        if (state_q == S_DIST) begin
          side_q <= 1'b0;
        end
      end
      S_HLD: begin
        if (!side_q) begin
          dist_q <= absv;
        end
        ext_q <= '0;
        k_q   <= '0;
      end
      S_HCAP: h_q <= rd_vec;
      S_EV2:  v_q <= rd_vec;
      S_EACC: begin
        ext_q <= sat_add(ext_q, prod);
        if (k_q != 2'd2) begin
          k_q <= k_q + 2'd1;
        end else if (!side_q) begin
          own_q  <= sat_add(ext_q, prod);
          side_q <= 1'b1;
        end
      end
      S_CMP: begin
        if (sep) begin
          ovl_q <= 1'b0;
        end
      end
      S_NEXT: begin
        unique case (grp_q)
          GrpFaceA: begin
            if (i_q == 2'd2) begin
              grp_q <= GrpFaceB;
              i_q   <= '0;
            end else begin
              i_q <= i_q + 2'd1;
            end
          end
          GrpFaceB: begin
            if (i_q == 2'd2) begin
              grp_q <= GrpCross;
              i_q   <= '0;
              j_q   <= '0;
            end else begin
              i_q <= i_q + 2'd1;
            end
          end
          GrpCross: begin
            if (j_q == 2'd2) begin
              j_q <= '0;
              i_q <= i_q + 2'd1;
            end else begin
              j_q <= j_q + 2'd1;
            end
          end
          default: grp_q <= GrpFaceA;
        endcase
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/obb_overlap_test_unit_chk.sv
// ----------------------------------------------------------------------------
// obb_overlap_test_unit_chk
// Port-level checks for the overlap unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "obb_overlap_test_unit_assert.svh"

module obb_overlap_test_unit_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic push,
  input logic full,
  input logic last_i,
  input logic empty,
  input logic pop,
  input logic overlap_o
);

  logic [3:0] pending_q;

  // Count tests requested but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 4'((push & ~full & last_i)) - 4'((pop & ~empty));
    end
  end

  `OBB_ASSERT_IMPL(a_no_spurious, !empty, pending_q != 4'd0, "result without a pending test")
  `OBB_ASSERT_IMPL(a_rst_empty, $rose(rst_ni), empty, "result queue not empty after reset")
  `OBB_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(overlap_o), "stalled result lost")

endmodule

bind obb_overlap_test_unit obb_overlap_test_unit_chk u_chk (.*);

>>> sim/obb_overlap_test_unit_test.sv
// ----------------------------------------------------------------------------
// Oriented box overlap unit testbench
// Drives vector loads and test requests through the push/full queue,
// predicts each overlap flag with a fixed point separating-axis model and
// compares every flag popped from the result queue in order.
// ----------------------------------------------------------------------------
module obb_overlap_test_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import obb_pkg::*;

  localparam int          FracBits   = FracBitsDef;
  localparam int          NumItems   = 1250;
  localparam int          CycleLimit = 20000000;
  localparam logic [2:0]  KindBad    = 3'd5;

  typedef int vec_t [3];

  // Scoreboard: shadow vector store, overlap predictor and pending flags.
  class overlap_board;
    int vecs [2][5][3];
    bit pending_flags [$];
    int mismatches;

    function new();
      foreach (vecs[b, k, c]) vecs[b][k][c] = 0;
      mismatches = 0;
    endfunction

    static function int sat32(longint v);
      if (v > 64'sh7fffffff) return 32'sh7fffffff;
      if (v < -64'sh80000000) return 32'sh80000000;
      return int'(v);
    endfunction

    static function int add(int a, int b); return sat32(longint'(a) + longint'(b)); endfunction
    static function int sub(int a, int b); return sat32(longint'(a) - longint'(b)); endfunction
    static function int mag(int a); return sat32(a < 0 ? -longint'(a) : longint'(a)); endfunction

    static function int mul(int a, int b);
      longint p;
      p = longint'(a) * longint'(b);
      return sat32(p / (longint'(1) << FracBits));
    endfunction

    static function int dot(vec_t a, vec_t b);
      return add(add(mul(a[0], b[0]), mul(a[1], b[1])), mul(a[2], b[2]));
    endfunction

    static function longint unsigned root(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function vec_t get(int b, int k);
      vec_t v;
      foreach (v[c]) v[c] = vecs[b][k][c];
      return v;
    endfunction

    // Sum over k of half[k] * |axis_k . d| for the given box.
    function int extent(int b, vec_t d);
      int s;
      vec_t h;
      s = 0;
      h = get(b, KindHalf);
      for (int k = 0; k < 3; k++) s = add(s, mul(h[k], mag(dot(get(b, 1 + k), d))));
      return s;
    endfunction

    function bit boxes_overlap();
      vec_t t, ha, hb, a, bv, cr, u;
      int absr [3][3];
      int own, oth;
      longint unsigned sq, len;
      ha = get(0, KindHalf);
      hb = get(1, KindHalf);
      for (int k = 0; k < 3; k++) t[k] = sub(vecs[1][0][k], vecs[0][0][k]);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          absr[i][j] = add(mag(dot(get(0, 1 + i), get(1, 1 + j))), 1);
      // face axes of the own box, then of the other box
      for (int i = 0; i < 3; i++) begin
        a = get(0, 1 + i);
        own = extent(0, a);
        oth = 0;
        for (int k = 0; k < 3; k++) oth = add(oth, mul(hb[k], absr[i][k]));
        if (mag(dot(t, a)) > add(own, oth)) return 1'b0;
      end
      for (int i = 0; i < 3; i++) begin
        bv = get(1, 1 + i);
        oth = extent(1, bv);
        own = 0;
        for (int k = 0; k < 3; k++) own = add(own, mul(ha[k], absr[k][i]));
        if (mag(dot(t, bv)) > add(own, oth)) return 1'b0;
      end
      // cross axes, skipped when degenerate
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          a = get(0, 1 + i);
          bv = get(1, 1 + j);
          cr[0] = sub(mul(a[1], bv[2]), mul(a[2], bv[1]));
          cr[1] = sub(mul(a[2], bv[0]), mul(a[0], bv[2]));
          cr[2] = sub(mul(a[0], bv[1]), mul(a[1], bv[0]));
          sq = 0;
          for (int k = 0; k < 3; k++) sq += longint'(cr[k]) * longint'(cr[k]);
          len = root(sq);
          if (len != 0) begin
            for (int k = 0; k < 3; k++)
              u[k] = sat32((longint'(cr[k]) * (longint'(1) << FracBits)) / longint'(len));
            if (mag(dot(t, u)) > add(extent(0, u), extent(1, u))) return 1'b0;
          end
        end
      end
      return 1'b1;
    endfunction

    function void note_load(bit b, logic [2:0] kind, int x, int y, int z, bit lst);
      if (kind <= KindHalf) begin
        vecs[b][kind][0] = x;
        vecs[b][kind][1] = y;
        vecs[b][kind][2] = z;
      end
      if (lst) pending_flags.push_back(boxes_overlap());
    endfunction

    function void check_flag(bit got);
      bit want;
      if (pending_flags.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: overlap=%0b", got);
        return;
      end
      want = pending_flags.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10) $display("overlap mismatch: expected %0b, got %0b", want, got);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic              box_select_i = 1'b0;
  logic [2:0]        vector_kind_i = KindCentre;
  logic signed [31:0] comp_x_i = '0;
  logic signed [31:0] comp_y_i = '0;
  logic signed [31:0] comp_z_i = '0;
  logic              last_i = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic              overlap_o;

  overlap_board board = new();
  int loads_sent = 0;
  int cycles = 0;

  obb_overlap_test_unit uut (
    .clk_i, .rst_ni, .push, .full, .box_select_i, .vector_kind_i,
    .comp_x_i, .comp_y_i, .comp_z_i, .last_i, .empty, .pop, .overlap_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: fail the run once it reaches the cycle limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Present one item and hold it until the block takes the transfer.
  task automatic send_load(bit b, logic [2:0] kind, int x, int y, int z, bit lst);
    int g;
    box_select_i  <= b;
    vector_kind_i <= kind;
    comp_x_i      <= x;
    comp_y_i      <= y;
    comp_z_i      <= z;
    last_i        <= lst;
    push          <= 1'b1;
    do @(posedge clk_i); while (full);
    board.note_load(b, kind, x, y, z, lst);
    loads_sent++;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Small signed wobble used to bend unit axes away from the ideal.
  function automatic int wobble(int amp);
    return $urandom_range(2 * amp) - amp;
  endfunction

  // Load a plausible box: permuted, sign-flipped unit axes with wobble.
  task automatic load_box(bit b, bit lst_at_end);
    int perm [3];
    int order [5];
    vec_t v;
    int tmp, j, one;
    one = 1 << FracBits;
    perm = '{0, 1, 2};
    perm.shuffle();
    order = '{0, 1, 2, 3, 4};
    order.shuffle();
    for (int n = 0; n < 5; n++) begin
      for (int c = 0; c < 3; c++) v[c] = 0;
      if (order[n] == KindCentre) begin
        for (int c = 0; c < 3; c++) v[c] = wobble(3 * one);
      end else if (order[n] == KindHalf) begin
        for (int c = 0; c < 3; c++) v[c] = $urandom_range(2 * one);
      end else begin
        j = perm[order[n] - 1];
        for (int c = 0; c < 3; c++) v[c] = wobble(one / 4);
        tmp = $urandom_range(1) ? one : -one;
        v[j] = v[j] + tmp;
      end
      send_load(b, 3'(order[n]), v[0], v[1], v[2], lst_at_end && n == 4);
    end
  endtask

  function automatic int any_word();
    int r;
    r = $urandom_range(5);
    if (r == 0) return 32'sh7fffffff;
    if (r == 1) return 32'sh80000000;
    return $urandom();
  endfunction

  initial begin : stimulus
    int one;
    one = 1 << FracBits;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Test on the cleared store: every cross axis is degenerate.
    send_load(1'b0, KindBad, 0, 0, 0, 1'b1);
    // Field extremes and out-of-range kinds, which store nothing.
    send_load(1'b0, KindCentre, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
    send_load(1'b1, KindCentre, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b1);
    send_load(1'b0, KindHalf, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
    send_load(1'b1, KindHalf, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1);
    send_load(1'b1, 3'd7, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
    send_load(1'b0, 3'd6, -1, -1, -1, 1'b0);
    // Axis-aligned boxes: first touching apart, then separated.
    send_load(1'b0, KindCentre, 0, 0, 0, 1'b0);
    send_load(1'b1, KindCentre, 2 * one, 0, 0, 1'b0);
    send_load(1'b0, KindAxis0, one, 0, 0, 1'b0);
    send_load(1'b0, KindAxis0 + 3'd1, 0, one, 0, 1'b0);
    send_load(1'b0, KindAxis0 + 3'd2, 0, 0, one, 1'b0);
    send_load(1'b1, KindAxis0, one, 0, 0, 1'b0);
    send_load(1'b1, KindAxis0 + 3'd1, 0, one, 0, 1'b0);
    send_load(1'b1, KindAxis0 + 3'd2, 0, 0, one, 1'b0);
    send_load(1'b0, KindHalf, one, one, one, 1'b0);
    send_load(1'b1, KindHalf, one, one, one, 1'b1);
    send_load(1'b1, KindCentre, 3 * one, 0, 0, 1'b1);
    send_load(1'b1, KindAxis0, one, 32'sh7fffffff, 32'sh80000000, 1'b1);

    while (loads_sent < NumItems) begin
      if ($urandom_range(9) < 8) begin
        load_box(1'b0, 1'b0);
        load_box(1'b1, 1'b1);
      end else begin
        // noise: raw words, any kind, last now and then
        repeat ($urandom_range(6, 1))
          send_load(1'($urandom_range(1)), 3'($urandom_range(7)), any_word(), any_word(),
                    any_word(), $urandom_range(3) == 0);
      end
    end
    push <= 1'b0;
    last_i <= 1'b0;

    wait (board.pending_flags.size() == 0);
    repeat (100) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: check each popped flag, then decide whether to stall.
  initial begin : drain
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) board.check_flag(overlap_o);
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        stall = gap_len();
        pop <= (stall == 0);
      end
    end
  end

endmodule

>>> files.f
+incdir+rtl
rtl/obb_pkg.sv
rtl/obb_fifo.sv
rtl/obb_ram.sv
rtl/obb_front.sv
rtl/obb_back.sv
rtl/obb_overlap_test_unit.sv
rtl/obb_overlap_test_unit_chk.sv
sim/obb_overlap_test_unit_test.sv
